// ===== hw/rtl/odm_pkg.sv =====
// ============================================================================
// odm_pkg
// Shared types and codes for the occupied density matrix block.
// ============================================================================
package odm_pkg;

    // fixed point layout of coefficients and results
    localparam int FRAC_BITS = 28;
    localparam int OUT_WIDTH = 48;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_ZERO  = 2'd1;
    localparam logic [1:0] CMD_BAD   = 2'd2;
    localparam logic [1:0] CMD_DOT   = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_BAD = 2'd1;
    localparam logic [1:0] STATUS_SAT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_ELECTRONS = 2'd1;
    localparam logic [1:0] REG_SPIN_MULT = 2'd2;
    localparam logic [1:0] REG_ORBITALS  = 2'd3;

    // item opcodes and modes
    localparam logic OP_WRITE          = 1'b0;
    localparam logic OP_READ           = 1'b1;
    localparam logic MODE_RESTRICTED   = 1'b0;
    localparam logic MODE_UNRESTRICTED = 1'b1;

    // configuration as seen by the front part
    typedef struct packed {
        logic       mode;
        logic [7:0] electron_count;
        logic [7:0] spin_multiplicity;
        logic [6:0] orbital_count;
    } cfg_t;

    // one classified command
    typedef struct packed {
        logic [1:0]  kind;
        logic        spin;
        logic [5:0]  row;
        logic [5:0]  column;
        logic [31:0] coefficient;
        logic [6:0]  count;
        logic        dbl;
        logic        odd;
    } cmd_t;

endpackage

// ===== hw/rtl/odm_ram.sv =====
// ============================================================================
// odm_ram
// Generic RAM, one write port and two registered read ports.
// ============================================================================
module odm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                           rdata_a,
    output logic [WIDTH-1:0]                           rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered reads
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== hw/rtl/odm_front.sv =====
// ============================================================================
// odm_front
// Input stage: takes items, checks settings and ranges, classifies them.
// ============================================================================
module odm_front #(
    parameter int MAX_ORBITALS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          opcode,
    input  logic          spin,
    input  logic [5:0]    row,
    input  logic [5:0]    column,
    input  logic [31:0]   coefficient,
    input  odm_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          busy,
    output logic          push,
    output odm_pkg::cmd_t cmd
);

    logic        in_v_reg;
    logic        in_v_next;
    logic        op_reg;
    logic        spin_reg;
    logic [5:0]  row_reg;
    logic [5:0]  col_reg;
    logic [31:0] coef_reg;

    logic        accept;
    logic        drop;
    logic        consume;
    logic [6:0]  norb;
    logic [8:0]  half_up;
    logic [8:0]  ne_sum;
    logic [7:0]  n_alpha;
    logic [7:0]  n_beta;
    logic [7:0]  n_occ;
    logic        bad;
    logic        out_of_range;
    logic        wr_in_range;

    // input handshake
    assign accept  = start && !busy;
    assign consume = in_v_reg && (drop || !q_full);
    assign busy    = in_v_reg && q_full && !drop;
    assign push    = in_v_reg && !drop && !q_full;

    always_comb
    begin
        in_v_next = in_v_reg;
        if (consume)
        begin
            in_v_next = 1'b0;
        end
        if (accept)
        begin
            in_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= in_v_next;
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            spin_reg <= spin;
            row_reg  <= row;
            col_reg  <= column;
            coef_reg <= coefficient;
        end
    end

    // effective orbital count
    assign norb = (11'(cfg.orbital_count) > 11'(MAX_ORBITALS)) ?
                  7'(MAX_ORBITALS) : cfg.orbital_count;

    // occupied counts
    assign half_up = (9'(cfg.electron_count) + 9'd1) >> 1;
    assign ne_sum  = 9'(cfg.electron_count) + 9'(cfg.spin_multiplicity) - 9'd1;
    assign n_alpha = ne_sum[8:1];
    assign n_beta  = cfg.electron_count - n_alpha;
    assign n_occ   = spin_reg ? n_beta : n_alpha;

    // settings check
    always_comb
    begin
        if (cfg.mode == odm_pkg::MODE_RESTRICTED)
        begin
            bad = (half_up > 9'(norb));
        end
        else
        begin
            bad = (cfg.spin_multiplicity == 8'd0)
               || (9'(cfg.spin_multiplicity) > 9'(cfg.electron_count) + 9'd1)
               || (cfg.spin_multiplicity[0] == cfg.electron_count[0])
               || (n_alpha > 8'(norb));
        end
    end

    assign out_of_range = (row_reg >= 6'(norb) && norb <= 7'd63)
                       || (col_reg >= 6'(norb) && norb <= 7'd63);
    assign wr_in_range  = (11'(row_reg) < 11'(MAX_ORBITALS))
                       && (11'(col_reg) < 11'(MAX_ORBITALS));
    assign drop         = (op_reg == odm_pkg::OP_WRITE) && !wr_in_range;

    // classification
    always_comb
    begin
        cmd.spin        = spin_reg;
        cmd.row         = row_reg;
        cmd.column      = col_reg;
        cmd.coefficient = coef_reg;
        cmd.count       = 7'(n_occ);
        cmd.dbl         = 1'b0;
        cmd.odd         = 1'b0;
        if (op_reg == odm_pkg::OP_WRITE)
        begin
            cmd.kind = odm_pkg::CMD_WRITE;
        end
        else if (bad)
        begin
            cmd.kind = odm_pkg::CMD_BAD;
        end
        else if (out_of_range)
        begin
            cmd.kind = odm_pkg::CMD_ZERO;
        end
        else
        begin
            cmd.kind = odm_pkg::CMD_DOT;
            if (cfg.mode == odm_pkg::MODE_RESTRICTED)
            begin
                cmd.spin  = 1'b0;
                cmd.count = 7'(half_up);
                cmd.dbl   = 1'b1;
                cmd.odd   = cfg.electron_count[0];
            end
        end
    end

endmodule

// ===== hw/rtl/odm_queue.sv =====
// ============================================================================
// odm_queue
// Two-entry command queue between the front and back parts.
// ============================================================================
module odm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  odm_pkg::cmd_t push_cmd,
    input  logic          pop,
    output odm_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    localparam int DEPTH = 2;

    odm_pkg::cmd_t entry_reg [DEPTH];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full  = (count_reg == 2'(DEPTH));
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/odm_back.sv =====
// ============================================================================
// odm_back
// Execution part: coefficient stores, multiply-accumulate, rounding, output.
// ============================================================================
module odm_back #(
    parameter int MAX_ORBITALS = 64,
    parameter int COEFF_WIDTH  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  odm_pkg::cmd_t head,
    input  logic          empty,
    output logic          pop,
    output logic          done,
    output logic [47:0]   density,
    output logic [1:0]    status
);

    localparam int W     = COEFF_WIDTH;
    localparam int L     = COEFF_WIDTH / 2;
    localparam int DEPTH = MAX_ORBITALS * MAX_ORBITALS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AXW   = AW + 8;
    localparam int PW    = 2 * COEFF_WIDTH + $clog2(MAX_ORBITALS) + 3;
    localparam int ACCW  = (PW > 80) ? PW : 80;
    localparam int FB    = odm_pkg::FRAC_BITS;
    localparam int OW    = odm_pkg::OUT_WIDTH;
    localparam logic signed [ACCW-1:0] DMAX =
        {{(ACCW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [ACCW-1:0] DMIN =
        {{(ACCW-OW+1){1'b1}}, {(OW-1){1'b0}}};
    localparam logic signed [ACCW-1:0] HALF =
        {{(ACCW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [6:0]  k_reg;
    logic [6:0]  k_next;

    // command being worked on
    logic        cur_spin_reg;
    logic [5:0]  cur_row_reg;
    logic [5:0]  cur_col_reg;
    logic [6:0]  cur_count_reg;
    logic        cur_dbl_reg;
    logic        cur_odd_reg;
    logic        load_cur;

    // memory ports
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [W-1:0]  wdata;
    logic          we_alpha;
    logic          we_beta;
    logic [W-1:0]  alpha_a;
    logic [W-1:0]  alpha_b;
    logic [W-1:0]  beta_a;
    logic [W-1:0]  beta_b;
    logic [W-1:0]  ca;
    logic [W-1:0]  cb;

    // datapath pipeline
    logic                        issue;
    logic                        issue_w2;
    logic                        v1_reg;
    logic                        w1_reg;
    logic                        v2_reg;
    logic                        w2_reg;
    logic                        v3_reg;
    logic                        w3_reg;
    logic signed [W+L:0]         plo_next;
    logic signed [W+L:0]         plo_reg;
    logic signed [2*W-L-1:0]     phi_next;
    logic signed [2*W-L-1:0]     phi_reg;
    logic signed [2*W-1:0]       prod_next;
    logic signed [2*W-1:0]       prod_reg;
    logic signed [ACCW-1:0]      addend;
    logic signed [ACCW-1:0]      acc_reg;
    logic                        acc_clr;
    logic signed [ACCW-1:0]      rnd_reg;
    logic signed [ACCW-1:0]      shifted;

    // result registers
    logic        done_reg;
    logic        done_next;
    logic [47:0] density_reg;
    logic [47:0] density_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic        out_load;

    // addresses: row-major, one row per basis function
    assign waddr   = AW'(AXW'(head.row) * AXW'(MAX_ORBITALS) + AXW'(head.column));
    assign raddr_a = AW'(AXW'(cur_row_reg) * AXW'(MAX_ORBITALS) + AXW'(k_reg));
    assign raddr_b = AW'(AXW'(cur_col_reg) * AXW'(MAX_ORBITALS) + AXW'(k_reg));
    assign wdata   = W'($signed(head.coefficient));

    odm_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_alpha (
        .clk     (clk),
        .we      (we_alpha),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (alpha_a),
        .rdata_b (alpha_b)
    );

    odm_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_beta (
        .clk     (clk),
        .we      (we_beta),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (beta_a),
        .rdata_b (beta_b)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        pop          = 1'b0;
        we_alpha     = 1'b0;
        we_beta      = 1'b0;
        load_cur     = 1'b0;
        acc_clr      = 1'b0;
        issue        = 1'b0;
        out_load     = 1'b0;
        done_next    = 1'b0;
        density_next = '0;
        status_next  = odm_pkg::STATUS_OK;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        odm_pkg::CMD_WRITE:
                        begin
                            we_alpha = !head.spin;
                            we_beta  = head.spin;
                        end
                        odm_pkg::CMD_ZERO:
                        begin
                            out_load  = 1'b1;
                            done_next = 1'b1;
                        end
                        odm_pkg::CMD_BAD:
                        begin
                            out_load    = 1'b1;
                            done_next   = 1'b1;
                            status_next = odm_pkg::STATUS_BAD;
                        end
                        odm_pkg::CMD_DOT:
                        begin
                            load_cur   = 1'b1;
                            acc_clr    = 1'b1;
                            k_next     = 7'd0;
                            state_next = (head.count == 7'd0) ? ST_DRAIN : ST_ISSUE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ISSUE:
            begin
                issue  = 1'b1;
                k_next = k_reg + 7'd1;
                if (k_reg == cur_count_reg - 7'd1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_load   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (shifted > DMAX)
                begin
                    density_next = DMAX[47:0];
                    status_next  = odm_pkg::STATUS_SAT;
                end
                else if (shifted < DMIN)
                begin
                    density_next = DMIN[47:0];
                    status_next  = odm_pkg::STATUS_SAT;
                end
                else
                begin
                    density_next = shifted[47:0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // in restricted mode the half-filled orbital of an odd count is added once, the rest twice
    assign issue_w2 = cur_dbl_reg && !(cur_odd_reg && (k_reg == cur_count_reg - 7'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 7'd0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            done_reg  <= done_next;
        end
    end

    // command latch
    always_ff @(posedge clk)
    begin
        if (load_cur)
        begin
            cur_spin_reg  <= head.spin;
            cur_row_reg   <= head.row;
            cur_col_reg   <= head.column;
            cur_count_reg <= head.count;
            cur_dbl_reg   <= head.dbl;
            cur_odd_reg   <= head.odd;
        end
    end

    // store select after the read
    assign ca = cur_spin_reg ? beta_a : alpha_a;
    assign cb = cur_spin_reg ? beta_b : alpha_b;

    // split multiply: low half of cb unsigned, high half signed
    assign plo_next  = $signed(ca) * $signed({1'b0, cb[L-1:0]});
    assign phi_next  = $signed(ca) * $signed(cb[W-1:L]);
    assign prod_next = ((2*W)'(phi_reg) <<< L) + (2*W)'(plo_reg);
    assign addend    = w3_reg ? ((ACCW)'(prod_reg) <<< 1) : (ACCW)'(prod_reg);

    always_ff @(posedge clk)
    begin
        w1_reg   <= issue_w2;
        w2_reg   <= w1_reg;
        w3_reg   <= w2_reg;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        prod_reg <= prod_next;
    end

    // accumulator and rounding
    always_ff @(posedge clk)
    begin
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_reg + addend;
        end
        if (state_reg == ST_ROUND)
        begin
            rnd_reg <= acc_reg + HALF;
        end
    end

    assign shifted = rnd_reg >>> FB;

    // result registers
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            density_reg <= density_next;
            status_reg  <= status_next;
        end
    end

    assign done    = done_reg;
    assign density = density_reg;
    assign status  = status_reg;

endmodule

// ===== hw/rtl/occupied_density_matrix_top.sv =====
// ============================================================================
// occupied_density_matrix_top
// Density matrix elements from stored occupied orbital coefficients.
// ============================================================================
// Items enter on start while busy is low: opcode 0 writes one Q4.28
// coefficient into the alpha or beta store, opcode 1 reads density element
// (row, column). Each read gives one result, on density and status for a
// single cycle marked by done; writes give none. Results leave in item order.
// A read walks its n occupied orbitals (restricted: (electron_count + 1) / 2)
// one coefficient pair per cycle through a single multiply-accumulate unit
// fed by the dual-read store, then rounds and saturates. Settings errors and
// out-of-range reads answer without the walk, and a write is stored straight
// from the head of the command queue into the alpha or beta store. A
// two-entry command queue sits between the input stage and the back end,
// so busy only rises when both queue entries and the input register are
// full. Configuration is written through cfg_valid/cfg_ready (always
// ready) by the user only while the block is idle; the block does not
// enforce this. Reset clears the registers to restricted mode, no
// electrons, multiplicity 1, 64 orbitals; coefficient stores are undefined
// until written. done is a pulse: the receiver cannot stall results.
// ============================================================================
module occupied_density_matrix_top #(
    parameter int MAX_ORBITALS = 64,
    parameter int COEFF_WIDTH  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic        spin,
    input  logic [5:0]  row,
    input  logic [5:0]  column,
    input  logic [31:0] coefficient,
    output logic        done,
    output logic [47:0] density,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    odm_pkg::cfg_t cfg_reg;
    odm_pkg::cfg_t cfg_next;
    odm_pkg::cmd_t push_cmd;
    odm_pkg::cmd_t head;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                odm_pkg::REG_MODE:      cfg_next.mode              = cfg_data[0];
                odm_pkg::REG_ELECTRONS: cfg_next.electron_count    = cfg_data;
                odm_pkg::REG_SPIN_MULT: cfg_next.spin_multiplicity = cfg_data;
                odm_pkg::REG_ORBITALS:  cfg_next.orbital_count     = cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode              <= odm_pkg::MODE_RESTRICTED;
            cfg_reg.electron_count    <= 8'd0;
            cfg_reg.spin_multiplicity <= 8'd1;
            cfg_reg.orbital_count     <= 7'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input stage and classification
    odm_front #(
        .MAX_ORBITALS (MAX_ORBITALS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .spin        (spin),
        .row         (row),
        .column      (column),
        .coefficient (coefficient),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .busy        (busy),
        .push        (push),
        .cmd         (push_cmd)
    );

    // command queue
    odm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // execution
    odm_back #(
        .MAX_ORBITALS (MAX_ORBITALS),
        .COEFF_WIDTH  (COEFF_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (q_empty),
        .pop     (pop),
        .done    (done),
        .density (density),
        .status  (status)
    );

endmodule
